// File: src/teot_pkg.sv
// shared codes and stream widths for the text edit transform block
`default_nettype none
package teot_pkg;

    localparam int IN_W  = 120;
    localparam int OUT_W = 112;

    localparam logic [1:0] ACT_OPEN    = 2'd0;
    localparam logic [1:0] ACT_REPLACE = 2'd1;
    localparam logic [1:0] ACT_BEGIN   = 2'd2;
    localparam logic [1:0] ACT_OP      = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RESYNC  = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

endpackage
`default_nettype wire

// File: src/text_edit_operational_transform.sv
// top level: document state, history ring, batch sequencer
// open, replace and begins judged at accept go straight to S_EMIT, which loads the result
// begin batch with history: S_GAPCHK, then one S_COPY step per history entry (none on a gap), then S_EMIT
// client op: S_XFORM moves it past each working copy, then S_PUSH and S_EMIT, one working-copy rmw per cycle
// one item is worked on at a time; the next is accepted the cycle after its result is loaded
// reset (rst_n low, async) clears length, version, ring pointers and batch state, not memories
`default_nettype none
module text_edit_operational_transform
    import teot_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256,
    parameter int MAX_BATCH     = 512,
    parameter int LENGTH_BITS   = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // version_value, length_value, op_count, op_kind, op_pos, op_len
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // action
    input  wire logic [1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // status, out_kind, out_pos, out_len, doc_version_out, doc_length_out
    output logic [OUT_W-1:0]      m_axis_tdata,
    // batch_done
    output logic                  m_axis_tlast
);

    localparam int LB = LENGTH_BITS;
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int HW = 33 + 2 * LB;
    localparam int WW = 1 + 2 * LB;
    localparam logic [LB-1:0] LMAX   = '1;
    localparam logic [31:0]   LMAX32 = 32'((64'd1 << LB) - 64'd1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_GAPCHK, S_COPY, S_XFORM, S_PUSH, S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [LB-1:0] doc_len_reg, doc_len_next, run_len_reg, run_len_next;
    logic [31:0]   doc_ver_reg, doc_ver_next, base_reg, base_next;
    logic [AW-1:0] hstart_reg, hstart_next, ptr_reg, ptr_next, pidx_reg, pidx_next;
    logic [CW-1:0] hcnt_reg, hcnt_next, wcnt_reg, wcnt_next, step_reg, step_next;
    logic [9:0]    remain_reg, remain_next, bcnt_reg, bcnt_next;
    logic          active_reg, active_next;
    logic          ckind_reg, ckind_next;
    logic [LB-1:0] cpos_reg, cpos_next, clen_reg, clen_next;
    logic [1:0]    status_reg, status_next;
    logic          done_reg, done_next;
    logic          mval_reg, mval_next, mlast_reg, mlast_next;
    logic [OUT_W-1:0] mdata_reg, mdata_next;

    logic          h_we, w_we;
    logic [AW-1:0] h_waddr, h_raddr, w_waddr, w_raddr;
    logic [HW-1:0] h_wdata, h_rdata;
    logic [WW-1:0] w_wdata, w_rdata;
    logic [LB-1:0] xc_pos, xc_len, xw_pos, xw_len;

    logic [31:0]   in_ver;
    logic [23:0]   in_len, in_pos, in_oplen;
    logic [9:0]    in_cnt;
    logic          in_kind, accept;
    logic [LB-1:0] lv, opos_c, room, olen_c, dp, de;
    logic [LB:0]   sum_w;
    logic [AW:0]   push_sum;
    logic [31:0]   ver_inc, pos32, len32;
    logic [32:0]   base_p1;
    logic [31:0]   out_pos32, out_len32, out_dlen32;

    teot_ram #(.WIDTH(HW), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    teot_ram #(.WIDTH(WW), .DEPTH(HISTORY_DEPTH)) u_work (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    // client op moved past the working copy, history wins insert ties
    teot_xform #(.LB(LB)) u_xf_client (
        .a_kind(ckind_reg), .a_pos(cpos_reg), .a_len(clen_reg),
        .b_kind(w_rdata[WW-1]), .b_pos(w_rdata[2*LB-1:LB]), .b_len(w_rdata[LB-1:0]),
        .b_wins(1'b1), .r_pos(xc_pos), .r_len(xc_len)
    );

    // working copy advanced past the client op
    teot_xform #(.LB(LB)) u_xf_work (
        .a_kind(w_rdata[WW-1]), .a_pos(w_rdata[2*LB-1:LB]), .a_len(w_rdata[LB-1:0]),
        .b_kind(ckind_reg), .b_pos(cpos_reg), .b_len(clen_reg),
        .b_wins(1'b0), .r_pos(xw_pos), .r_len(xw_len)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

    assign in_ver   = s_axis_tdata[31:0];
    assign in_len   = s_axis_tdata[55:32];
    assign in_cnt   = s_axis_tdata[65:56];
    assign in_kind  = s_axis_tdata[66];
    assign in_pos   = s_axis_tdata[90:67];
    assign in_oplen = s_axis_tdata[114:91];

    always_comb
    begin
        state_next  = state_reg;
        doc_len_next = doc_len_reg;
        doc_ver_next = doc_ver_reg;
        run_len_next = run_len_reg;
        base_next   = base_reg;
        hstart_next = hstart_reg;
        ptr_next    = ptr_reg;
        pidx_next   = pidx_reg;
        hcnt_next   = hcnt_reg;
        wcnt_next   = wcnt_reg;
        step_next   = step_reg;
        remain_next = remain_reg;
        bcnt_next   = bcnt_reg;
        active_next = active_reg;
        ckind_next  = ckind_reg;
        cpos_next   = cpos_reg;
        clen_next   = clen_reg;
        status_next = status_reg;
        done_next   = done_reg;
        mval_next   = mval_reg && !m_axis_tready;
        mlast_next  = mlast_reg;
        mdata_next  = mdata_reg;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = hstart_reg;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;

        ver_inc = (doc_ver_reg == 32'hFFFF_FFFF) ? doc_ver_reg : doc_ver_reg + 32'd1;
        base_p1 = {1'b0, base_reg} + 33'd1;
        lv      = (32'(in_len) > LMAX32) ? LMAX : LB'(32'(in_len));
        pos32   = 32'(in_pos);
        len32   = 32'(in_oplen);
        opos_c  = (pos32 > 32'(run_len_reg)) ? run_len_reg : LB'(pos32);
        room    = run_len_reg - opos_c;
        olen_c  = '0;
        sum_w   = '0;
        dp      = (cpos_reg < doc_len_reg) ? cpos_reg : doc_len_reg;
        de      = '0;
        out_pos32  = 32'(cpos_reg);
        out_len32  = 32'(clen_reg);
        out_dlen32 = 32'(doc_len_reg);
        push_sum = (AW+1)'(hstart_reg) + (AW+1)'(hcnt_reg);
        if (push_sum >= DEPTH_W)
        begin
            push_sum = push_sum - DEPTH_W;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_EMIT;
                    status_next = ST_OK;
                    done_next   = 1'b0;
                    ckind_next  = KIND_INSERT;
                    cpos_next   = '0;
                    clen_next   = '0;
                    case (s_axis_tuser)
                        ACT_OPEN:
                        begin
                            doc_ver_next = in_ver;
                            doc_len_next = lv;
                            active_next  = 1'b0;
                            remain_next  = '0;
                        end
                        ACT_REPLACE:
                        begin
                            doc_len_next = lv;
                            doc_ver_next = ver_inc;
                            hstart_next  = '0;
                            hcnt_next    = '0;
                            active_next  = 1'b0;
                            remain_next  = '0;
                        end
                        ACT_BEGIN:
                        begin
                            active_next = 1'b0;
                            remain_next = '0;
                            wcnt_next   = '0;
                            base_next   = in_ver;
                            bcnt_next   = in_cnt;
                            if (in_cnt == '0 || in_cnt > 10'(MAX_BATCH))
                            begin
                                status_next = ST_REJECT;
                            end
                            else if (in_ver > doc_ver_reg)
                            begin
                                status_next = ST_RESYNC;
                            end
                            else if (in_ver < doc_ver_reg)
                            begin
                                if (hcnt_reg == '0)
                                begin
                                    status_next = ST_RESYNC;
                                end
                                else
                                begin
                                    // oldest entry is read for the gap check
                                    h_raddr    = hstart_reg;
                                    state_next = S_GAPCHK;
                                end
                            end
                            else
                            begin
                                run_len_next = doc_len_reg;
                                remain_next  = in_cnt;
                                active_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!active_reg || remain_reg == '0)
                            begin
                                status_next = ST_IGNORED;
                            end
                            else
                            begin
                                ckind_next = in_kind;
                                cpos_next  = opos_c;
                                if (in_kind == KIND_INSERT)
                                begin
                                    olen_c = (len32 > LMAX32) ? LMAX : LB'(len32);
                                    sum_w  = {1'b0, run_len_reg} + {1'b0, olen_c};
                                    run_len_next = sum_w[LB] ? LMAX : sum_w[LB-1:0];
                                end
                                else
                                begin
                                    olen_c = (len32 > 32'(room)) ? room : LB'(len32);
                                    run_len_next = run_len_reg - olen_c;
                                end
                                clen_next = olen_c;
                                if (wcnt_reg == '0)
                                begin
                                    state_next = S_PUSH;
                                end
                                else
                                begin
                                    w_raddr    = '0;
                                    pidx_next  = '0;
                                    step_next  = CW'(1);
                                    state_next = S_XFORM;
                                end
                            end
                        end
                    endcase
                end
            end
            S_GAPCHK:
            begin
                if ({1'b0, h_rdata[HW-1:WW]} > base_p1)
                begin
                    status_next = ST_RESYNC;
                    state_next  = S_EMIT;
                end
                else
                begin
                    h_raddr    = hstart_reg;
                    ptr_next   = (hstart_reg == LAST_IDX) ? '0 : hstart_reg + AW'(1);
                    step_next  = CW'(1);
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                // keep entries newer than the base as working copies
                if (h_rdata[HW-1:WW] > base_reg)
                begin
                    w_we      = 1'b1;
                    w_waddr   = wcnt_reg[AW-1:0];
                    w_wdata   = h_rdata[WW-1:0];
                    wcnt_next = wcnt_reg + CW'(1);
                end
                if (step_reg < hcnt_reg)
                begin
                    h_raddr   = ptr_reg;
                    ptr_next  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + AW'(1);
                    step_next = step_reg + CW'(1);
                end
                else
                begin
                    run_len_next = doc_len_reg;
                    remain_next  = bcnt_reg;
                    active_next  = 1'b1;
                    status_next  = ST_OK;
                    state_next   = S_EMIT;
                end
            end
            S_XFORM:
            begin
                cpos_next = xc_pos;
                clen_next = xc_len;
                w_we      = 1'b1;
                w_waddr   = pidx_reg;
                w_wdata   = {w_rdata[WW-1], xw_pos, xw_len};
                if (step_reg < wcnt_reg)
                begin
                    w_raddr   = step_reg[AW-1:0];
                    pidx_next = step_reg[AW-1:0];
                    step_next = step_reg + CW'(1);
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (ckind_reg == KIND_INSERT)
                begin
                    sum_w = {1'b0, doc_len_reg} + {1'b0, clen_reg};
                    doc_len_next = sum_w[LB] ? LMAX : sum_w[LB-1:0];
                end
                else
                begin
                    sum_w = {1'b0, dp} + {1'b0, clen_reg};
                    de    = (sum_w > {1'b0, doc_len_reg}) ? doc_len_reg : sum_w[LB-1:0];
                    doc_len_next = doc_len_reg - (de - dp);
                end
                h_we    = 1'b1;
                h_wdata = {ver_inc, ckind_reg, cpos_reg, clen_reg};
                if (hcnt_reg < DEPTH_C)
                begin
                    h_waddr   = push_sum[AW-1:0];
                    hcnt_next = hcnt_reg + CW'(1);
                end
                else
                begin
                    // full ring: overwrite the oldest
                    h_waddr     = hstart_reg;
                    hstart_next = (hstart_reg == LAST_IDX) ? '0 : hstart_reg + AW'(1);
                end
                remain_next = remain_reg - 10'd1;
                status_next = ST_OK;
                if (remain_reg == 10'd1)
                begin
                    doc_ver_next = ver_inc;
                    active_next  = 1'b0;
                    done_next    = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!mval_reg || m_axis_tready)
                begin
                    mval_next  = 1'b1;
                    mlast_next = done_reg;
                    mdata_next = {5'd0, out_dlen32[23:0], doc_ver_reg, out_len32[23:0],
                                  out_pos32[23:0], ckind_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            doc_len_reg <= '0;
            doc_ver_reg <= '0;
            run_len_reg <= '0;
            hstart_reg  <= '0;
            hcnt_reg    <= '0;
            wcnt_reg    <= '0;
            remain_reg  <= '0;
            active_reg  <= 1'b0;
            mval_reg    <= 1'b0;
            mlast_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            doc_len_reg <= doc_len_next;
            doc_ver_reg <= doc_ver_next;
            run_len_reg <= run_len_next;
            hstart_reg  <= hstart_next;
            hcnt_reg    <= hcnt_next;
            wcnt_reg    <= wcnt_next;
            remain_reg  <= remain_next;
            active_reg  <= active_next;
            mval_reg    <= mval_next;
            mlast_reg   <= mlast_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        bcnt_reg   <= bcnt_next;
        ptr_reg    <= ptr_next;
        pidx_reg   <= pidx_next;
        step_reg   <= step_next;
        ckind_reg  <= ckind_next;
        cpos_reg   <= cpos_next;
        clen_reg   <= clen_next;
        status_reg <= status_next;
        mdata_reg  <= mdata_next;
    end

endmodule
`default_nettype wire

// File: src/teot_ram.sv
// generic single write port ram with registered read
`default_nettype none
module teot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/teot_xform.sv
// shifts edit a so that it applies after edit b
`default_nettype none
module teot_xform
    import teot_pkg::*;
#(
    parameter int LB = 24
) (
    input  wire logic          a_kind,
    input  wire logic [LB-1:0] a_pos,
    input  wire logic [LB-1:0] a_len,
    input  wire logic          b_kind,
    input  wire logic [LB-1:0] b_pos,
    input  wire logic [LB-1:0] b_len,
    input  wire logic          b_wins,
    output logic      [LB-1:0] r_pos,
    output logic      [LB-1:0] r_len
);

    logic [LB:0]   pos_raw, len_raw, a_end, b_end, lo, hi, shared;
    logic [LB-1:0] pos_sat, len_sat, lead_cut;
    logic          ins_hit;

    always_comb
    begin
        pos_raw  = {1'b0, a_pos} + {1'b0, b_len};
        len_raw  = {1'b0, a_len} + {1'b0, b_len};
        pos_sat  = pos_raw[LB] ? '1 : pos_raw[LB-1:0];
        len_sat  = len_raw[LB] ? '1 : len_raw[LB-1:0];
        a_end    = {1'b0, a_pos} + {1'b0, a_len};
        b_end    = {1'b0, b_pos} + {1'b0, b_len};
        ins_hit  = b_wins ? (b_pos <= a_pos) : (b_pos < a_pos);
        lead_cut = (b_pos < a_pos) ? a_pos - b_pos : '0;
        lo       = (a_pos > b_pos) ? {1'b0, a_pos} : {1'b0, b_pos};
        hi       = (a_end < b_end) ? a_end : b_end;
        shared   = (hi > lo) ? hi - lo : '0;
        r_pos    = a_pos;
        r_len    = a_len;
        if (b_kind == KIND_INSERT)
        begin
            if (a_kind == KIND_INSERT)
            begin
                if (ins_hit)
                begin
                    r_pos = pos_sat;
                end
            end
            else if (b_pos <= a_pos)
            begin
                r_pos = pos_sat;
            end
            else if ({1'b0, b_pos} < a_end)
            begin
                r_len = len_sat;
            end
        end
        else if (b_end <= {1'b0, a_pos})
        begin
            r_pos = a_pos - b_len;
        end
        else if (a_kind == KIND_INSERT)
        begin
            if (b_pos < a_pos)
            begin
                r_pos = b_pos;
            end
        end
        else if ({1'b0, b_pos} < a_end)
        begin
            // overlapping deletes: drop the shared span
            r_pos = a_pos - lead_cut;
            r_len = (shared > {1'b0, a_len}) ? '0 : a_len - shared[LB-1:0];
        end
    end

endmodule
`default_nettype wire

// File: src/teot_checker.sv
// port-level checks for the text edit transform block, bound to the top level
`default_nettype none
module teot_checker
    import teot_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic [IN_W-1:0]  s_axis_tdata,
    input wire logic [1:0]       s_axis_tuser,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // only a committed op closes a batch
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == ST_OK)
        else $error("batch done with bad status");

    // non-ok results carry no transformed op
    a_zero_op: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[50:2] == '0)
        else $error("op fields set on non-ok result");

endmodule

bind text_edit_operational_transform teot_checker u_teot_checker (.*);
`default_nettype wire
